[hw/rtl/hird_pkg.sv]
// shared types and constants for the hvac ineffective-run detector
// no dependencies; used by every module of the block
`default_nettype none

package hird_pkg;

    // field widths
    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 15;
    localparam int MODE_W  = 2;
    // signed width that holds any difference of two temperatures exactly
    localparam int DIFF_W  = TEMP_W + 2;

    // configuration port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 3;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_SETPOINT_MOVE_LIMIT = 3'd0;
    localparam logic [INDEX_W-1:0] REG_MIN_PROGRESS        = 3'd1;
    localparam logic [INDEX_W-1:0] REG_COOL_SUPPLY_DELTA   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_HEAT_SUPPLY_DELTA   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SUPPLY_MIN_RUN      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_MIN_RUN             = 3'd5;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_SETPOINT_MOVE_LIMIT = 15'd50;
    localparam logic [LIMIT_W-1:0] RST_MIN_PROGRESS        = 15'd30;
    localparam logic [LIMIT_W-1:0] RST_COOL_SUPPLY_DELTA   = 15'd800;
    localparam logic [LIMIT_W-1:0] RST_HEAT_SUPPLY_DELTA   = 15'd1100;
    localparam logic [TIME_W-1:0]  RST_SUPPLY_MIN_RUN      = 32'd600;
    localparam logic [TIME_W-1:0]  RST_MIN_RUN             = 32'd1800;

    // equipment mode codes; both remaining codes are heating kinds
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COOL = 2'd1;

    // input transaction
    typedef struct packed {
        logic [MODE_W-1:0]        equip_mode;
        logic                     room_ok;
        logic                     room_poor;
        logic signed [TEMP_W-1:0] room_temp;
        logic signed [TEMP_W-1:0] target_temp;
        logic                     supply_ok;
        logic signed [TEMP_W-1:0] supply_temp;
        logic [TIME_W-1:0]        now_seconds;
    } sample_t;

    // output transaction
    typedef struct packed {
        logic [MODE_W-1:0] mode_echo;
        logic              ineffective;
    } result_t;

    // configuration register set
    typedef struct packed {
        logic [LIMIT_W-1:0] setpoint_move_limit;
        logic [LIMIT_W-1:0] min_progress;
        logic [LIMIT_W-1:0] cool_supply_delta;
        logic [LIMIT_W-1:0] heat_supply_delta;
        logic [TIME_W-1:0]  supply_min_run;
        logic [TIME_W-1:0]  min_run;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/hird_cfg_regs.sv]
// apb-style configuration register file for the ineffective-run detector
// depends on hird_pkg for register indexes, reset values and cfg_t
`default_nettype none

module hird_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hird_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hird_pkg::DATA_W-1:0]   pwdata,
    output logic      [hird_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output hird_pkg::cfg_t                     cfg
);

    hird_pkg::cfg_t                cfg_reg;
    logic [hird_pkg::INDEX_W-1:0]  index;
    logic                          wr_en;

    // word index from the byte address
    assign index  = paddr[hird_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint_move_limit <= hird_pkg::RST_SETPOINT_MOVE_LIMIT;
            cfg_reg.min_progress        <= hird_pkg::RST_MIN_PROGRESS;
            cfg_reg.cool_supply_delta   <= hird_pkg::RST_COOL_SUPPLY_DELTA;
            cfg_reg.heat_supply_delta   <= hird_pkg::RST_HEAT_SUPPLY_DELTA;
            cfg_reg.supply_min_run      <= hird_pkg::RST_SUPPLY_MIN_RUN;
            cfg_reg.min_run             <= hird_pkg::RST_MIN_RUN;
        end
        else if (wr_en)
        begin
            unique case (index)
                hird_pkg::REG_SETPOINT_MOVE_LIMIT:
                    cfg_reg.setpoint_move_limit <= pwdata[hird_pkg::LIMIT_W-1:0];
                hird_pkg::REG_MIN_PROGRESS:
                    cfg_reg.min_progress <= pwdata[hird_pkg::LIMIT_W-1:0];
                hird_pkg::REG_COOL_SUPPLY_DELTA:
                    cfg_reg.cool_supply_delta <= pwdata[hird_pkg::LIMIT_W-1:0];
                hird_pkg::REG_HEAT_SUPPLY_DELTA:
                    cfg_reg.heat_supply_delta <= pwdata[hird_pkg::LIMIT_W-1:0];
                hird_pkg::REG_SUPPLY_MIN_RUN:
                    cfg_reg.supply_min_run <= pwdata[hird_pkg::TIME_W-1:0];
                hird_pkg::REG_MIN_RUN:
                    cfg_reg.min_run <= pwdata[hird_pkg::TIME_W-1:0];
                default:
                begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (index)
            hird_pkg::REG_SETPOINT_MOVE_LIMIT:
                prdata = {{(hird_pkg::DATA_W-hird_pkg::LIMIT_W){1'b0}},
                          cfg_reg.setpoint_move_limit};
            hird_pkg::REG_MIN_PROGRESS:
                prdata = {{(hird_pkg::DATA_W-hird_pkg::LIMIT_W){1'b0}},
                          cfg_reg.min_progress};
            hird_pkg::REG_COOL_SUPPLY_DELTA:
                prdata = {{(hird_pkg::DATA_W-hird_pkg::LIMIT_W){1'b0}},
                          cfg_reg.cool_supply_delta};
            hird_pkg::REG_HEAT_SUPPLY_DELTA:
                prdata = {{(hird_pkg::DATA_W-hird_pkg::LIMIT_W){1'b0}},
                          cfg_reg.heat_supply_delta};
            hird_pkg::REG_SUPPLY_MIN_RUN:
                prdata = cfg_reg.supply_min_run;
            hird_pkg::REG_MIN_RUN:
                prdata = cfg_reg.min_run;
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/hird_episode.sv]
// episode state and verdict logic: one sample evaluated per enabled cycle
// depends on hird_pkg for sample_t, cfg_t and mode codes
`default_nettype none

module hird_episode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire hird_pkg::sample_t    sample,
    input  wire hird_pkg::cfg_t       cfg,
    output logic                      ineffective
);

    localparam int DW = hird_pkg::DIFF_W;

    // episode state
    logic                             episode_active_reg, episode_active_next;
    logic [hird_pkg::MODE_W-1:0]      episode_mode_reg, episode_mode_next;
    logic [hird_pkg::TIME_W-1:0]      episode_start_reg, episode_start_next;
    logic signed [hird_pkg::TEMP_W-1:0] worst_room_reg, worst_room_next;
    logic signed [hird_pkg::TEMP_W-1:0] episode_target_reg, episode_target_next;
    logic                             progress_seen_reg, progress_seen_next;
    logic                             verdict_latch_reg, verdict_latch_next;

    // working values
    logic                             bad_room;
    logic                             restart;
    logic                             cooling;
    logic signed [DW-1:0]             room_w, target_w, supply_w;
    logic signed [DW-1:0]             sp_move, sp_abs;
    logic [hird_pkg::TIME_W-1:0]      start_eff;
    logic signed [hird_pkg::TEMP_W-1:0] worst_eff;
    logic signed [DW-1:0]             worst_w;
    logic                             prog_eff, latch_eff;
    logic [hird_pkg::TIME_W-1:0]      run;
    logic signed [DW-1:0]             move, delta, need;
    logic                             healthy, failed;

    always_comb
    begin
        bad_room = (sample.equip_mode == hird_pkg::MODE_IDLE) || !sample.room_ok
                   || sample.room_poor;

        room_w   = DW'(sample.room_temp);
        target_w = DW'(sample.target_temp);
        supply_w = DW'(sample.supply_temp);

        // setpoint move against the episode baseline
        sp_move = target_w - DW'(episode_target_reg);
        sp_abs  = (sp_move < 0) ? -sp_move : sp_move;
        restart = !episode_active_reg || (sample.equip_mode != episode_mode_reg)
                  || (sp_abs > $signed(DW'({1'b0, cfg.setpoint_move_limit})));

        // baseline after a possible restart
        start_eff = restart ? sample.now_seconds : episode_start_reg;
        worst_eff = restart ? sample.room_temp : worst_room_reg;
        prog_eff  = restart ? 1'b0 : progress_seen_reg;
        latch_eff = restart ? 1'b0 : verdict_latch_reg;
        worst_w   = DW'(worst_eff);

        cooling = (sample.equip_mode == hird_pkg::MODE_COOL);
        run     = sample.now_seconds - start_eff;

        // progress from the worst point, compared as signed values
        move = cooling ? (worst_w - room_w) : (room_w - worst_w);
        progress_seen_next = prog_eff
                             || (move >= $signed(DW'({1'b0, cfg.min_progress})));

        // worst room tracking
        if (cooling ? (room_w > worst_w) : (room_w < worst_w))
            worst_room_next = sample.room_temp;
        else
            worst_room_next = worst_eff;

        // supply delta rule
        delta   = cooling ? (room_w - supply_w) : (supply_w - room_w);
        need    = cooling ? DW'({1'b0, cfg.cool_supply_delta})
                          : DW'({1'b0, cfg.heat_supply_delta});
        healthy = sample.supply_ok && (delta >= need);
        failed  = sample.supply_ok && !(delta >= need) && (run >= cfg.supply_min_run);

        // verdict rules in priority order
        priority if (healthy)
            verdict_latch_next = 1'b0;
        else if (failed)
            verdict_latch_next = 1'b1;
        else if ((run >= cfg.min_run) && !progress_seen_next)
            verdict_latch_next = 1'b1;
        else if (progress_seen_next)
            verdict_latch_next = 1'b0;
        else
            verdict_latch_next = latch_eff;

        episode_active_next = 1'b1;
        episode_mode_next   = sample.equip_mode;
        episode_start_next  = start_eff;
        episode_target_next = restart ? sample.target_temp : episode_target_reg;

        // idle or untrusted room ends the episode
        if (bad_room)
        begin
            episode_active_next = 1'b0;
            episode_start_next  = '0;
            worst_room_next     = '0;
            episode_target_next = '0;
            progress_seen_next  = 1'b0;
            verdict_latch_next  = 1'b0;
        end

        ineffective = verdict_latch_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            episode_active_reg <= 1'b0;
            episode_mode_reg   <= hird_pkg::MODE_IDLE;
            episode_start_reg  <= '0;
            worst_room_reg     <= '0;
            episode_target_reg <= '0;
            progress_seen_reg  <= 1'b0;
            verdict_latch_reg  <= 1'b0;
        end
        else if (step)
        begin
            episode_active_reg <= episode_active_next;
            episode_mode_reg   <= episode_mode_next;
            episode_start_reg  <= episode_start_next;
            worst_room_reg     <= worst_room_next;
            episode_target_reg <= episode_target_next;
            progress_seen_reg  <= progress_seen_next;
            verdict_latch_reg  <= verdict_latch_next;
        end
    end

    // a verdict only exists inside an episode
    a_verdict_in_episode: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_latch_reg |-> episode_active_reg)
        else $error("verdict latched without an active episode");

    // progress only exists inside an episode
    a_progress_in_episode: assert property (@(posedge clk) disable iff (!rst_n)
        progress_seen_reg |-> episode_active_reg)
        else $error("progress latched without an active episode");

    // an ended episode leaves a cleared baseline
    a_cleared_baseline: assert property (@(posedge clk) disable iff (!rst_n)
        !episode_active_reg |-> (episode_start_reg == '0 && worst_room_reg == '0
                                 && episode_target_reg == '0))
        else $error("inactive episode holds a stale baseline");

endmodule

`default_nettype wire

[hw/rtl/hvac_ineffective_run_detector_unit.sv]
// top level of the hvac ineffective-run detector: sample register, episode
// logic and result register; depends on hird_pkg, hird_cfg_regs, hird_episode
`default_nettype none

// usage
// - sample channel: sample_valid / sample_stall / sample carry one sensor
//   reading per transaction; a transaction completes when valid is high and
//   stall is low at a rising edge
// - result channel: result_valid / result_stall / result return one verdict
//   transaction (mode echo and ineffective flag) per sample, in order
// - configuration: apb-style port, register i at byte address 4*i; write only
//   while no sample is in flight; reads return the stored value
// - path: a sample lands in the input register and is evaluated against the
//   episode state into the result register when that register can take a
//   new value
// - throughput: one sample per cycle while the result is not stalled; the
//   evaluation is one pass of compare and subtract logic between the registers
// - receiver stall: the result register holds; the input register still
//   takes a sample if empty, then sample_stall rises until the result moves
// - reset: thresholds return to their defaults, no episode runs, both
//   registers empty
module hvac_ineffective_run_detector_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output logic                             sample_stall,
    input  wire hird_pkg::sample_t           sample,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output hird_pkg::result_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hird_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hird_pkg::DATA_W-1:0] pwdata,
    output logic      [hird_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    hird_pkg::cfg_t      cfg;
    hird_pkg::sample_t   stage_reg;
    logic                stage_valid_reg;
    hird_pkg::result_t   result_reg, result_next;
    logic                result_valid_reg;
    logic                advance;
    logic                step;
    logic                ineffective;

    hird_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register can take a new value
    assign advance      = !result_valid_reg || !result_stall;
    assign step         = stage_valid_reg && advance;
    assign sample_stall = stage_valid_reg && !advance;

    hird_episode u_episode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .sample      (stage_reg),
        .cfg         (cfg),
        .ineffective (ineffective)
    );

    always_comb
    begin
        result_next.mode_echo   = stage_reg.equip_mode;
        result_next.ineffective = ineffective;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (!sample_stall)
            stage_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            stage_reg <= sample;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a full input register behind a stalled result must push back
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && result_valid_reg && result_stall) |-> sample_stall)
        else $error("sample taken while pipeline is blocked");

    // an evaluated sample appears as a result on the next edge
    a_step_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (result_valid_reg && result_reg.mode_echo == $past(stage_reg.equip_mode)))
        else $error("evaluated sample did not reach the result register");

    // idle mode never reports a verdict
    a_idle_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.mode_echo == hird_pkg::MODE_IDLE)
        |-> !result_reg.ineffective)
        else $error("verdict reported for an idle sample");

endmodule

`default_nettype wire

[dv/hvac_ineffective_run_detector_unit_tb.sv]
// testbench for hvac_ineffective_run_detector_unit: directed and random sensor samples,
// apb threshold writes, random idling on both channels; depends on hird_pkg and the rtl
`timescale 1ns / 100ps

module hvac_ineffective_run_detector_unit_tb;

    // heating kinds and register indexes with no register behind them
    localparam logic [hird_pkg::MODE_W-1:0]  MODE_HEAT     = 2'd2;
    localparam logic [hird_pkg::MODE_W-1:0]  MODE_HEAT_ALT = 2'd3;
    localparam logic [hird_pkg::INDEX_W-1:0] REG_SPARE     = 3'd6;
    localparam logic [hird_pkg::INDEX_W-1:0] REG_SPARE_TOP = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 130;

    // episode tracker and verdict predictor with its queue of pending verdicts
    class verdict_scoreboard;
        int          sp_limit;
        int          progress_min;
        int          cool_delta;
        int          heat_delta;
        logic [31:0] supply_run;
        logic [31:0] trend_run;

        bit                          active;
        logic [hird_pkg::MODE_W-1:0] ep_mode;
        logic [31:0]                 ep_start;
        int                          worst;
        int                          ep_target;
        bit                          progressed;
        bit                          verdict;

        hird_pkg::result_t verdict_q[$];
        int                mismatches;

        function new();
            sp_limit     = int'(hird_pkg::RST_SETPOINT_MOVE_LIMIT);
            progress_min = int'(hird_pkg::RST_MIN_PROGRESS);
            cool_delta   = int'(hird_pkg::RST_COOL_SUPPLY_DELTA);
            heat_delta   = int'(hird_pkg::RST_HEAT_SUPPLY_DELTA);
            supply_run   = hird_pkg::RST_SUPPLY_MIN_RUN;
            trend_run    = hird_pkg::RST_MIN_RUN;
            ep_mode      = hird_pkg::MODE_IDLE;
            mismatches   = 0;
            clear_episode();
        endfunction

        function void clear_episode();
            active     = 1'b0;
            ep_start   = '0;
            worst      = 0;
            ep_target  = 0;
            progressed = 1'b0;
            verdict    = 1'b0;
        endfunction

        function void configure(logic [hird_pkg::INDEX_W-1:0] idx, logic [31:0] value);
            case (idx)
                hird_pkg::REG_SETPOINT_MOVE_LIMIT:
                    sp_limit = int'(value[hird_pkg::LIMIT_W-1:0]);
                hird_pkg::REG_MIN_PROGRESS:
                    progress_min = int'(value[hird_pkg::LIMIT_W-1:0]);
                hird_pkg::REG_COOL_SUPPLY_DELTA:
                    cool_delta = int'(value[hird_pkg::LIMIT_W-1:0]);
                hird_pkg::REG_HEAT_SUPPLY_DELTA:
                    heat_delta = int'(value[hird_pkg::LIMIT_W-1:0]);
                hird_pkg::REG_SUPPLY_MIN_RUN:
                    supply_run = value;
                hird_pkg::REG_MIN_RUN:
                    trend_run = value;
                default: ;
            endcase
        endfunction

        // work out the verdict for one accepted sample
        function void note_sample(hird_pkg::sample_t s);
            hird_pkg::result_t r;
            int                room;
            int                target;
            int                supply;
            int                sp_move;
            int                move;
            int                delta;
            int                need;
            logic [31:0]       run;
            bit                cooling;
            bit                healthy;
            bit                failed;
            room          = int'($signed(s.room_temp));
            target        = int'($signed(s.target_temp));
            supply        = int'($signed(s.supply_temp));
            healthy       = 1'b0;
            failed        = 1'b0;
            r.mode_echo   = s.equip_mode;
            r.ineffective = 1'b0;
            if (s.equip_mode == hird_pkg::MODE_IDLE || !s.room_ok || s.room_poor) begin
                clear_episode();
                ep_mode = s.equip_mode;
            end
            else begin
                sp_move = target - ep_target;
                if (sp_move < 0)
                    sp_move = -sp_move;
                // fresh baseline on start, mode change or large setpoint move
                if (!active || s.equip_mode != ep_mode || sp_move > sp_limit) begin
                    active     = 1'b1;
                    ep_mode    = s.equip_mode;
                    ep_start   = s.now_seconds;
                    worst      = room;
                    ep_target  = target;
                    progressed = 1'b0;
                    verdict    = 1'b0;
                end
                cooling = (ep_mode == hird_pkg::MODE_COOL);
                run     = s.now_seconds - ep_start;
                move    = cooling ? (worst - room) : (room - worst);
                if (move >= progress_min)
                    progressed = 1'b1;
                if (cooling ? (room > worst) : (room < worst))
                    worst = room;
                if (s.supply_ok) begin
                    delta = cooling ? (room - supply) : (supply - room);
                    need  = cooling ? cool_delta : heat_delta;
                    if (delta >= need)
                        healthy = 1'b1;
                    else if (run >= supply_run)
                        failed = 1'b1;
                end
                if (healthy)
                    verdict = 1'b0;
                else if (failed)
                    verdict = 1'b1;
                else if (run >= trend_run && !progressed)
                    verdict = 1'b1;
                else if (progressed)
                    verdict = 1'b0;
                r.ineffective = verdict;
            end
            verdict_q.push_back(r);
        endfunction

        // compare one result transaction against the oldest pending verdict
        function void check_result(hird_pkg::result_t got);
            hird_pkg::result_t want;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none pending: mode %0d ineffective %0b",
                             $realtime, got.mode_echo, got.ineffective);
            end
            else begin
                want = verdict_q.pop_front();
                if (got.mode_echo !== want.mode_echo ||
                    got.ineffective !== want.ineffective) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result mismatch: mode exp %0d got %0d, ",
                                  "ineffective exp %0b got %0b"}, $realtime,
                                 want.mode_echo, got.mode_echo,
                                 want.ineffective, got.ineffective);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    hird_pkg::sample_t             sample;
    logic                          result_valid;
    logic                          result_stall;
    hird_pkg::result_t             result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [hird_pkg::ADDR_W-1:0]   paddr;
    logic [hird_pkg::DATA_W-1:0]   pwdata;
    logic [hird_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    verdict_scoreboard sb = new();
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;

    hvac_ineffective_run_detector_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hvac_ineffective_run_detector_unit_tb: FAIL");
            $finish;
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int hold_count;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                result_stall = 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            result_stall = idle_on && ($urandom_range(99) < 11);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic logic signed [hird_pkg::TEMP_W-1:0] to_temp(int v);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[hird_pkg::TEMP_W-1:0];
    endfunction

    function automatic hird_pkg::sample_t make_sample(logic [hird_pkg::MODE_W-1:0] mode,
                                                      bit ok, bit poor, int room,
                                                      int target, bit sok, int supply,
                                                      logic [31:0] now);
        hird_pkg::sample_t s;
        s.equip_mode  = mode;
        s.room_ok     = ok;
        s.room_poor   = poor;
        s.room_temp   = to_temp(room);
        s.target_temp = to_temp(target);
        s.supply_ok   = sok;
        s.supply_temp = to_temp(supply);
        s.now_seconds = now;
        return s;
    endfunction

    // offer one sample transaction; called and returns at a falling edge
    task automatic send_sample(input hird_pkg::sample_t s);
        if (idle_on && $urandom_range(99) < 11) begin
            sample_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        sample       = s;
        sample_valid = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(s);
        items_sent++;
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (sb.verdict_q.size() != 0)
            @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic cfg_write(input logic [hird_pkg::INDEX_W-1:0] idx,
                             input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.configure(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_thresholds(input logic [31:0] sp, input logic [31:0] prog,
                                  input logic [31:0] cool, input logic [31:0] heat,
                                  input logic [31:0] smr, input logic [31:0] mr);
        drain_results();
        cfg_write(hird_pkg::REG_SETPOINT_MOVE_LIMIT, sp);
        cfg_write(hird_pkg::REG_MIN_PROGRESS, prog);
        cfg_write(hird_pkg::REG_COOL_SUPPLY_DELTA, cool);
        cfg_write(hird_pkg::REG_HEAT_SUPPLY_DELTA, heat);
        cfg_write(hird_pkg::REG_SUPPLY_MIN_RUN, smr);
        cfg_write(hird_pkg::REG_MIN_RUN, mr);
    endtask

    // one plausible run of the equipment with drifting room and supply readings
    task automatic run_episode(input int len);
        logic [hird_pkg::MODE_W-1:0] mode;
        logic [31:0]                 now;
        int                          room;
        int                          target;
        int                          supply;
        int                          span;
        int                          pick;
        int                          i;
        bit                          ok;
        bit                          poor;
        mode   = hird_pkg::MODE_W'($urandom_range(1, 3));
        room   = int'($urandom_range(0, 6000)) - 3000;
        target = room + int'($urandom_range(0, 800)) - 400;
        now    = $urandom;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            ok   = 1'b1;
            poor = 1'b0;
            if (pick < 3)
                mode = hird_pkg::MODE_W'($urandom_range(1, 3));
            else if (pick < 9) begin
                span   = sb.sp_limit + 1;
                target = target + int'($urandom_range(0, 2 * span)) - span;
            end
            else if (pick < 11)
                ok = 1'b0;
            else if (pick < 13)
                poor = 1'b1;
            if (pick >= 97)
                now = now - $urandom_range(1, 3);
            else if (pick == 96)
                now = now - $urandom_range(1, 5000);
            else
                now = now + $urandom_range(0, 400);
            span = sb.progress_min + 10;
            room = room + int'($urandom_range(0, 2 * span)) - span;
            if (room > 32767)
                room = 32767;
            else if (room < -32768)
                room = -32768;
            span = ((mode == hird_pkg::MODE_COOL) ? sb.cool_delta : sb.heat_delta) + 10;
            if (mode == hird_pkg::MODE_COOL)
                supply = room - int'($urandom_range(0, 2 * span));
            else
                supply = room + int'($urandom_range(0, 2 * span));
            send_sample(make_sample((pick == 50) ? hird_pkg::MODE_IDLE : mode, ok, poor,
                                    room, target, $urandom_range(9) != 0, supply, now));
        end
    endtask

    // fully random sample fields
    task automatic send_noise();
        logic [95:0]       bits;
        hird_pkg::sample_t s;
        bits = {$urandom, $urandom, $urandom};
        s    = bits[$bits(hird_pkg::sample_t)-1:0];
        send_sample(s);
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                run_episode($urandom_range(5, 30));
            else
                repeat ($urandom_range(1, 5)) send_noise();
        end
    endtask

    task automatic random_thresholds();
        set_thresholds($urandom_range(0, 300) | ($urandom & 32'hFFFF_8000),
                       $urandom_range(0, 100), $urandom_range(0, 1500),
                       $urandom_range(0, 1500) | ($urandom & 32'hFFFF_8000),
                       $urandom_range(0, 3000), $urandom_range(0, 5000));
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed samples under the reset thresholds
        send_sample(make_sample(hird_pkg::MODE_IDLE, 1'b1, 1'b0, 32767, -32768, 1'b1,
                                -32768, 32'hFFFF_FFFF));
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b0, 1'b0, -32768, 32767, 1'b1,
                                32767, 0));
        send_sample(make_sample(MODE_HEAT, 1'b1, 1'b1, 2000, 2200, 1'b1, 3000, 10));
        // cooling: supply delta exactly at threshold, then failing delivery
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2600, 2200, 1'b1,
                                1800, 1000));
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2600, 2200, 1'b1,
                                1900, 1599));
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2600, 2200, 1'b1,
                                1900, 1600));
        // progress exactly at threshold clears the verdict
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2570, 2200, 1'b0,
                                0, 1700));
        // setpoint move at the limit keeps the episode, a larger one restarts it
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2580, 2250, 1'b0,
                                0, 1750));
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2580, 2301, 1'b0,
                                0, 1800));
        // no-progress timeout
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 2580, 2301, 1'b0,
                                0, 3600));
        // heating kinds, switch between them restarts
        send_sample(make_sample(MODE_HEAT, 1'b1, 1'b0, 1800, 2200, 1'b1, 2900, 5000));
        send_sample(make_sample(MODE_HEAT_ALT, 1'b1, 1'b0, 1800, 2200, 1'b1, 2900, 5100));
        send_sample(make_sample(MODE_HEAT_ALT, 1'b1, 1'b0, 1800, 2200, 1'b0, 0, 6900));
        send_sample(make_sample(MODE_HEAT_ALT, 1'b1, 1'b0, 1830, 2200, 1'b0, 0, 7000));
        // timestamp going backwards reads as a long run
        send_sample(make_sample(MODE_HEAT_ALT, 1'b1, 1'b0, 1830, 2200, 1'b1, 1835, 4000));
        // temperature extremes
        send_sample(make_sample(MODE_HEAT_ALT, 1'b1, 1'b0, -32768, 2200, 1'b1,
                                32767, 4001));
        send_sample(make_sample(hird_pkg::MODE_COOL, 1'b1, 1'b0, 32767, -32768, 1'b1,
                                -32768, 4002));
        send_sample(make_sample(hird_pkg::MODE_IDLE, 1'b0, 1'b1, 0, 0, 1'b0, 0, 4003));
        send_sample(make_sample(MODE_HEAT, 1'b1, 1'b0, -32768, 32767, 1'b1, -32768, 0));
        send_sample(make_sample(MODE_HEAT, 1'b1, 1'b0, -32768, 32767, 1'b1, -32768,
                                32'hFFFF_FFFF));

        // random episodes under the reset thresholds
        run_phase(PHASE_ITEMS);

        // all thresholds at zero, writes to unused indexes ignored
        set_thresholds(0, 0, 0, 0, 0, 0);
        cfg_write(REG_SPARE, $urandom);
        cfg_write(REG_SPARE_TOP, $urandom);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);

        // all thresholds at their top, upper data bits dropped on narrow registers
        set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_7FFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(PHASE_ITEMS);

        random_thresholds();
        run_phase(PHASE_ITEMS / 2);
        drain_results();
        run_phase(PHASE_ITEMS / 2);

        // stretch with no idling on either side
        random_thresholds();
        idle_on = 1'b0;
        run_phase(PHASE_ITEMS);
        idle_on = 1'b1;

        random_thresholds();
        run_phase(PHASE_ITEMS);

        // wind down
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.verdict_q.size() == 0)
            $display("hvac_ineffective_run_detector_unit_tb: PASS");
        else
            $display("hvac_ineffective_run_detector_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hird_pkg.sv
hw/rtl/hird_cfg_regs.sv
hw/rtl/hird_episode.sv
hw/rtl/hvac_ineffective_run_detector_unit.sv
dv/hvac_ineffective_run_detector_unit_tb.sv
